### rtl/sad_pkg.sv
// Package for the sprite attribute decoder: board mode codes, register
// indexes, field widths and fixed decode constants. No dependencies.
package sad_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned ScrollW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned TileW  = 11;
  localparam int unsigned XPosW  = 12;
  localparam int unsigned YPosW  = 10;

  typedef enum logic [ModeW-1:0] {
    MODE_IK16  = 3'd0,
    MODE_IK32  = 3'd1,
    MODE_TK    = 3'd2,
    MODE_TDF   = 3'd3,
    MODE_GW16  = 3'd4,
    MODE_GW32  = 3'd5
  } board_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOARD_MODE = 3'd0,
    REG_X_SCROLL   = 3'd1,
    REG_Y_SCROLL   = 3'd2,
    REG_SHADOW_ON  = 3'd3
  } cfg_reg_t;

  // Edge fold limits on the 9-bit coordinate
  localparam logic [8:0] FoldBig   = 9'd480;
  localparam logic [8:0] FoldSmall = 9'd496;

  localparam logic [XPosW-1:0] IkXOfs  = 12'd8;
  localparam logic [XPosW-1:0] IkYOfs  = 12'd272;
  localparam logic [XPosW-1:0] IkYHalf = 12'd256;

  localparam logic [7:0] PenShadow = 8'd7;
  localparam logic [7:0] PenMask   = 8'hC0;
  localparam logic [7:0] PenHigh   = 8'd15;

endpackage

### rtl/sprite_attribute_decoder.sv
// Sprite attribute decoder top level: one 4-byte sprite entry in, one set
// of drawing parameters out. Depends on sad_pkg.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------------
//  input   | in_x_byte in_tile_byte in_y_byte in_attr_byte | start & !busy
//  result  | out_tile_index .. out_trans_value             | out_valid, one cycle
//  config  | cfg_we cfg_index cfg_wdata                    | cfg_we, no wait
//
// The accepting edge loads the input register; the next edge loads the
// decode into the result register, which drives the ports and is flagged
// by out_valid for one cycle. busy stays low: a word can be taken
// every cycle. rst_n is synchronous; it clears the valid flags and sets the
// config registers to mode 0, no scroll, shadow on.
// The receiver cannot stall; out_valid lasts exactly one cycle per word.
module sprite_attribute_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_x_byte,
  input  logic [7:0]                    in_tile_byte,
  input  logic [7:0]                    in_y_byte,
  input  logic [7:0]                    in_attr_byte,
  output logic                          out_valid,
  output logic [sad_pkg::TileW-1:0]     out_tile_index,
  output logic [3:0]                    out_color_code,
  output logic signed [sad_pkg::XPosW-1:0] out_x_pos,
  output logic signed [sad_pkg::YPosW-1:0] out_y_pos,
  output logic                          out_y_flip,
  output logic                          out_trans_kind,
  output logic [7:0]                    out_trans_value,
  input  logic                          cfg_we,
  input  logic [sad_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sad_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int unsigned XW = sad_pkg::XPosW;
  localparam int unsigned YW = sad_pkg::YPosW;

  // configuration
  logic [sad_pkg::ModeW-1:0]   mode_r;
  logic [sad_pkg::ScrollW-1:0] x_scroll_r;
  logic [sad_pkg::ScrollW-1:0] y_scroll_r;
  logic                        shadow_on_r;

  // input register
  logic       in_vld_r;
  logic [7:0] xb_r, tb_r, yb_r, ab_r;

  // decode results
  logic [sad_pkg::TileW-1:0] tile_nxt;
  logic [3:0]                color_nxt;
  logic [XW-1:0]             x_nxt;
  logic [YW-1:0]             y_nxt;
  logic                      flip_nxt, kind_nxt;
  logic [7:0]                tval_nxt;

  logic [XW-1:0] xs, ys, xsum, ysum, xlin, ylin, yneg;
  logic [YW-1:0] xfold_big, xfold_small, yfold_big, ynfold_big, yfold_small;
  logic          ikari_trans;

  function automatic logic [sad_pkg::YPosW-1:0] fold9(input logic [8:0] v,
                                                      input logic [8:0] limit);
    fold9 = {(v > limit), v};
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sad_pkg::MODE_IK16;
      x_scroll_r  <= '0;
      y_scroll_r  <= '0;
      shadow_on_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sad_pkg::REG_BOARD_MODE: mode_r      <= cfg_wdata[sad_pkg::ModeW-1:0];
        sad_pkg::REG_X_SCROLL:   x_scroll_r  <= cfg_wdata[sad_pkg::ScrollW-1:0];
        sad_pkg::REG_Y_SCROLL:   y_scroll_r  <= cfg_wdata[sad_pkg::ScrollW-1:0];
        sad_pkg::REG_SHADOW_ON:  shadow_on_r <= cfg_wdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_valid <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      xb_r <= in_x_byte;
      tb_r <= in_tile_byte;
      yb_r <= in_y_byte;
      ab_r <= in_attr_byte;
    end
    if (in_vld_r) begin
      out_tile_index  <= tile_nxt;
      out_color_code  <= color_nxt;
      out_x_pos       <= x_nxt;
      out_y_pos       <= y_nxt;
      out_y_flip      <= flip_nxt;
      out_trans_kind  <= kind_nxt;
      out_trans_value <= tval_nxt;
    end
  end

  // Position arithmetic, all modulo 4096; the 9-bit modes take the low bits.
  always_comb begin
    xs   = {{(XW-sad_pkg::ScrollW){x_scroll_r[sad_pkg::ScrollW-1]}}, x_scroll_r};
    ys   = {{(XW-sad_pkg::ScrollW){y_scroll_r[sad_pkg::ScrollW-1]}}, y_scroll_r};
    xsum = {3'b000, ab_r[4], xb_r};
    ysum = {3'b000, ab_r[7], yb_r};
    xlin = xsum - xs;          // x + xhi - xs
    ylin = ysum - ys;          // y + yhi - ys
    yneg = {XW{1'b0}} - ylin;  // ys - y - yhi
    xfold_big   = fold9(xlin[8:0], sad_pkg::FoldBig);
    xfold_small = fold9(xlin[8:0], sad_pkg::FoldSmall);
    yfold_big   = fold9(ylin[8:0], sad_pkg::FoldBig);
    ynfold_big  = fold9(yneg[8:0], sad_pkg::FoldBig);
    yfold_small = fold9(ylin[8:0], sad_pkg::FoldSmall);
  end

  always_comb begin
    logic [XW-1:0] xt, yt;
    xt          = '0;
    yt          = '0;
    tile_nxt    = {1'b0, ab_r[6:5], tb_r};
    color_nxt   = ab_r[3:0];
    x_nxt       = '0;
    y_nxt       = '0;
    flip_nxt    = 1'b0;
    ikari_trans = 1'b0;
    tval_nxt    = sad_pkg::PenHigh;
    unique case (mode_r)
      sad_pkg::MODE_IK32: begin
        tile_nxt    = {2'b00, ab_r[6], tb_r};
        xt          = xlin - sad_pkg::IkXOfs;
        yt          = sad_pkg::IkYHalf - ylin;
        x_nxt       = {3'b000, xt[8:0]};
        y_nxt       = {1'b0, yt[8:0]};
        ikari_trans = 1'b1;
      end
      sad_pkg::MODE_TK: begin
        tile_nxt = {2'b00, ab_r[6], tb_r};
        yt       = sad_pkg::IkYHalf - ylin;
        x_nxt    = xlin;  // no 9-bit wrap here
        y_nxt    = {1'b0, yt[8:0]};
        tval_nxt = sad_pkg::PenShadow;
      end
      sad_pkg::MODE_TDF: begin
        x_nxt = {{(XW-YW){xfold_big[YW-1]}}, xfold_big};
        y_nxt = ynfold_big;
      end
      sad_pkg::MODE_GW16: begin
        tile_nxt  = {ab_r[6], ab_r[5], ab_r[3], tb_r};
        color_nxt = {1'b0, ab_r[2:0]};
        x_nxt     = {{(XW-YW){xfold_small[YW-1]}}, xfold_small};
        y_nxt     = yfold_small;
        flip_nxt  = 1'b1;
      end
      sad_pkg::MODE_GW32: begin
        x_nxt    = {{(XW-YW){xfold_big[YW-1]}}, xfold_big};
        y_nxt    = yfold_big;
        flip_nxt = 1'b1;
      end
      default: begin
        // mode 0 and the unused codes
        xt          = xlin + sad_pkg::IkXOfs;
        yt          = sad_pkg::IkYOfs - ylin;
        x_nxt       = {3'b000, xt[8:0]};
        y_nxt       = {1'b0, yt[8:0]};
        ikari_trans = 1'b1;
      end
    endcase
    kind_nxt = ikari_trans && !shadow_on_r;
    if (ikari_trans) begin
      tval_nxt = shadow_on_r ? sad_pkg::PenShadow : sad_pkg::PenMask;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("accepted word produced no result");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_valid)
    else $error("result without an accepted word");

  a_flip_pen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_y_flip |-> !out_trans_kind && out_trans_value == sad_pkg::PenHigh)
    else $error("flipped sprite with wrong transparency");

  a_mask_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trans_kind |-> out_trans_value == sad_pkg::PenMask && !out_y_flip)
    else $error("pen mask result inconsistent");
`endif

endmodule
